@@ design/msm_pkg.sv @@
// Package for the misfire speed modulator: widths, curve selector and curve tables.
// Used by every module of the block; depends on nothing.
package msm_pkg;

    localparam int TEETH_DEFAULT = 240;
    localparam int SPEED_W       = 14;
    localparam int STRENGTH_W    = 15;
    localparam int PATTERN_W     = 4;
    localparam int TOOTH_W       = 8;
    localparam int OUT_W         = 16;
    localparam int CURVE_W       = 17;   // signed Q15 curve sample
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 2'd2;

    typedef enum logic [1:0] {
        CURVE_OFF = 2'd0,
        CURVE_A   = 2'd1,
        CURVE_B   = 2'd2,
        CURVE_C   = 2'd3
    } t_curve;

    // Quarter sine, Q15, 61 points
    function automatic logic [15:0] sine_quarter(input logic [5:0] k);
        logic [15:0] v;
        unique case (k)
            6'd0: v = 16'h0000; 6'd1: v = 16'h0359; 6'd2: v = 16'h06b2; 6'd3: v = 16'h0a0a;
            6'd4: v = 16'h0d61; 6'd5: v = 16'h10b4; 6'd6: v = 16'h1405; 6'd7: v = 16'h1753;
            6'd8: v = 16'h1a9c; 6'd9: v = 16'h1de1; 6'd10: v = 16'h2120; 6'd11: v = 16'h245a;
            6'd12: v = 16'h278d; 6'd13: v = 16'h2ab9; 6'd14: v = 16'h2dde; 6'd15: v = 16'h30fb;
            6'd16: v = 16'h340f; 6'd17: v = 16'h371a; 6'd18: v = 16'h3a1b; 6'd19: v = 16'h3d13;
            6'd20: v = 16'h3fff; 6'd21: v = 16'h42e0; 6'd22: v = 16'h45b6; 6'd23: v = 16'h487f;
            6'd24: v = 16'h4b3b; 6'd25: v = 16'h4deb; 6'd26: v = 16'h508c; 6'd27: v = 16'h5320;
            6'd28: v = 16'h55a5; 6'd29: v = 16'h581b; 6'd30: v = 16'h5a81; 6'd31: v = 16'h5cd8;
            6'd32: v = 16'h5f1e; 6'd33: v = 16'h6154; 6'd34: v = 16'h6378; 6'd35: v = 16'h658b;
            6'd36: v = 16'h678d; 6'd37: v = 16'h697c; 6'd38: v = 16'h6b58; 6'd39: v = 16'h6d22;
            6'd40: v = 16'h6ed9; 6'd41: v = 16'h707c; 6'd42: v = 16'h720b; 6'd43: v = 16'h7387;
            6'd44: v = 16'h74ee; 6'd45: v = 16'h7640; 6'd46: v = 16'h777e; 6'd47: v = 16'h78a7;
            6'd48: v = 16'h79bb; 6'd49: v = 16'h7ab9; 6'd50: v = 16'h7ba2; 6'd51: v = 16'h7c75;
            6'd52: v = 16'h7d32; 6'd53: v = 16'h7dda; 6'd54: v = 16'h7e6b; 6'd55: v = 16'h7ee6;
            6'd56: v = 16'h7f4b; 6'd57: v = 16'h7f99; 6'd58: v = 16'h7fd2; 6'd59: v = 16'h7ff3;
            6'd60: v = 16'h7fff;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // Half of the slow lobe of curve A, 91 points
    function automatic logic [15:0] lobe_half(input logic [6:0] j);
        logic [15:0] v;
        unique case (j)
            7'd0: v = 16'h0000; 7'd1: v = 16'h00be; 7'd2: v = 16'h017d; 7'd3: v = 16'h023b;
            7'd4: v = 16'h02f9; 7'd5: v = 16'h03b7; 7'd6: v = 16'h0475; 7'd7: v = 16'h0533;
            7'd8: v = 16'h05f0; 7'd9: v = 16'h06ac; 7'd10: v = 16'h0768; 7'd11: v = 16'h0824;
            7'd12: v = 16'h08de; 7'd13: v = 16'h0998; 7'd14: v = 16'h0a52; 7'd15: v = 16'h0b0a;
            7'd16: v = 16'h0bc2; 7'd17: v = 16'h0c79; 7'd18: v = 16'h0d2f; 7'd19: v = 16'h0de3;
            7'd20: v = 16'h0e97; 7'd21: v = 16'h0f4a; 7'd22: v = 16'h0ffb; 7'd23: v = 16'h10ab;
            7'd24: v = 16'h115a; 7'd25: v = 16'h1207; 7'd26: v = 16'h12b4; 7'd27: v = 16'h135e;
            7'd28: v = 16'h1407; 7'd29: v = 16'h14af; 7'd30: v = 16'h1555; 7'd31: v = 16'h15f9;
            7'd32: v = 16'h169b; 7'd33: v = 16'h173c; 7'd34: v = 16'h17db; 7'd35: v = 16'h1878;
            7'd36: v = 16'h1913; 7'd37: v = 16'h19ad; 7'd38: v = 16'h1a44; 7'd39: v = 16'h1ad9;
            7'd40: v = 16'h1b6c; 7'd41: v = 16'h1bfd; 7'd42: v = 16'h1c8c; 7'd43: v = 16'h1d19;
            7'd44: v = 16'h1da3; 7'd45: v = 16'h1e2b; 7'd46: v = 16'h1eb0; 7'd47: v = 16'h1f34;
            7'd48: v = 16'h1fb4; 7'd49: v = 16'h2033; 7'd50: v = 16'h20ae; 7'd51: v = 16'h2128;
            7'd52: v = 16'h219e; 7'd53: v = 16'h2212; 7'd54: v = 16'h2284; 7'd55: v = 16'h22f3;
            7'd56: v = 16'h235f; 7'd57: v = 16'h23c8; 7'd58: v = 16'h242e; 7'd59: v = 16'h2492;
            7'd60: v = 16'h24f3; 7'd61: v = 16'h2550; 7'd62: v = 16'h25ab; 7'd63: v = 16'h2603;
            7'd64: v = 16'h2658; 7'd65: v = 16'h26aa; 7'd66: v = 16'h26fa; 7'd67: v = 16'h2746;
            7'd68: v = 16'h278f; 7'd69: v = 16'h27d4; 7'd70: v = 16'h2817; 7'd71: v = 16'h2857;
            7'd72: v = 16'h2893; 7'd73: v = 16'h28cd; 7'd74: v = 16'h2903; 7'd75: v = 16'h2936;
            7'd76: v = 16'h2965; 7'd77: v = 16'h2992; 7'd78: v = 16'h29bb; 7'd79: v = 16'h29e1;
            7'd80: v = 16'h2a04; 7'd81: v = 16'h2a23; 7'd82: v = 16'h2a40; 7'd83: v = 16'h2a58;
            7'd84: v = 16'h2a6e; 7'd85: v = 16'h2a80; 7'd86: v = 16'h2a8f; 7'd87: v = 16'h2a9b;
            7'd88: v = 16'h2aa3; 7'd89: v = 16'h2aa8; 7'd90: v = 16'h2aaa;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // Signed sine over one 240-point period, k in 0..239
    function automatic logic signed [CURVE_W-1:0] sine240(input logic [7:0] k);
        logic [7:0]  h;
        logic [7:0]  q;
        logic [15:0] m;
        h = (k >= 8'd120) ? k - 8'd120 : k;
        q = (h <= 8'd60) ? h : 8'd120 - h;
        m = sine_quarter(q[5:0]);
        return (k >= 8'd120) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

@@ design/msm_index.sv @@
// Index stage: reduces the tooth and subtracts the pattern offset modulo the cycle.
// Depends on msm_pkg.
module msm_index #(
    parameter int TEETH_PER_CYCLE = msm_pkg::TEETH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_valid,
    input  logic [msm_pkg::TOOTH_W-1:0] i_tooth,
    input  logic [msm_pkg::PATTERN_W-1:0] i_pattern,
    output logic                        o_valid,
    output logic [msm_pkg::TOOTH_W-1:0] o_index,
    output msm_pkg::t_curve             o_curve
);
    import msm_pkg::*;

    localparam logic [TOOTH_W:0] TEETH = (TOOTH_W+1)'(TEETH_PER_CYCLE);

    logic [TOOTH_W-1:0] n_tooth;
    logic [TOOTH_W-1:0] n_offset;
    logic [TOOTH_W:0]   n_diff;
    t_curve             n_curve;
    logic               r_valid;
    logic [TOOTH_W-1:0] r_index;
    t_curve             r_curve;

    // Decode the two lowest set bits of the pattern
    always_comb begin
        n_curve  = CURVE_OFF;
        n_offset = '0;
        unique case (i_pattern)
            4'b0000: begin n_curve = CURVE_OFF; n_offset = 8'd0;   end
            4'b0001, 4'b0011, 4'b0101, 4'b0111, 4'b1011, 4'b1101, 4'b1111,
            4'b1001: begin
                n_offset = 8'd40;
                if (i_pattern == 4'b0001) n_curve = CURVE_A;
                else if (i_pattern[1:0] == 2'b11) n_curve = CURVE_B;
                else if (i_pattern[2]) n_curve = CURVE_C;
                else begin n_curve = CURVE_B; n_offset = 8'd220; end
            end
            4'b0010, 4'b0110, 4'b1010, 4'b1110: begin
                n_offset = 8'd100;
                if (i_pattern == 4'b0010) n_curve = CURVE_A;
                else if (i_pattern[2]) n_curve = CURVE_B;
                else n_curve = CURVE_C;
            end
            4'b0100, 4'b1100: begin
                n_offset = 8'd160;
                n_curve  = (i_pattern[3]) ? CURVE_B : CURVE_A;
            end
            4'b1000: begin n_curve = CURVE_A; n_offset = 8'd220; end
            default: begin n_curve = CURVE_OFF; n_offset = 8'd0; end
        endcase
    end

    // Reduce tooth and subtract offset modulo the cycle
    always_comb begin
        n_tooth = ({1'b0, i_tooth} >= TEETH) ? i_tooth - TEETH[TOOTH_W-1:0] : i_tooth;
        n_diff  = {1'b0, n_tooth} - {1'b0, n_offset};
        if (n_diff[TOOTH_W]) n_diff = n_diff + TEETH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_index <= n_diff[TOOTH_W-1:0];
            r_curve <= n_curve;
        end
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_curve = r_curve;

    // Index always stays inside the cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_index} < TEETH))
        else $error("index out of cycle");
endmodule

@@ design/msm_curve.sv @@
// Curve stage: looks up the signed Q15 disturbance sample for an index.
// Depends on msm_pkg.
module msm_curve (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_valid,
    input  logic [msm_pkg::TOOTH_W-1:0]       i_index,
    input  msm_pkg::t_curve                   i_curve,
    output logic                              o_valid,
    output logic signed [msm_pkg::CURVE_W-1:0] o_sample
);
    import msm_pkg::*;

    logic [TOOTH_W:0]            n_dbl;
    logic [TOOTH_W-1:0]          n_dmod;
    logic [TOOTH_W-1:0]          n_j;
    logic signed [CURVE_W-1:0]   n_sample;
    logic                        r_valid;
    logic signed [CURVE_W-1:0]   r_sample;

    // Pick the sample from the selected curve
    always_comb begin
        n_dbl  = {i_index, 1'b0};
        n_dmod = (n_dbl >= 9'd240) ? 8'(n_dbl - 9'd240) : n_dbl[TOOTH_W-1:0];
        n_j    = (i_index >= 8'd240) ? 8'd180 : i_index - 8'd60;
        if (n_j > 8'd180) n_j = 8'd180;
        unique case (i_curve)
            CURVE_OFF: n_sample = '0;
            CURVE_B:   n_sample = -sine240(i_index);
            CURVE_C:   n_sample = -sine240(n_dmod);
            CURVE_A: begin
                if (i_index < 8'd60)
                    n_sample = -sine240(n_dbl[TOOTH_W-1:0]);
                else if (n_j <= 8'd90)
                    n_sample = $signed({1'b0, lobe_half(n_j[6:0])});
                else
                    n_sample = $signed({1'b0, lobe_half(7'(8'd180 - n_j))});
            end
            default:   n_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) r_sample <= n_sample;
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

    // Samples never exceed full scale
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_sample <= 17'sd32767 && r_sample >= -17'sd32767))
        else $error("curve sample out of range");
endmodule

@@ design/msm_scale.sv @@
// Scale stages: curve*strength>>15, then *2*speed>>15, then add the doubled speed.
// Depends on msm_pkg.
module msm_scale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_advance,
    input  logic                               i_valid,
    input  logic signed [msm_pkg::CURVE_W-1:0] i_sample,
    input  logic [msm_pkg::STRENGTH_W-1:0]     i_strength,
    input  logic [msm_pkg::SPEED_W-1:0]        i_speed,
    output logic                               o_valid,
    output logic [msm_pkg::OUT_W-1:0]          o_speed
);
    import msm_pkg::*;

    logic signed [32:0]          n_p1;
    logic signed [32:0]          n_p2;
    logic signed [OUT_W+1:0]     n_sum;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic signed [CURVE_W-1:0]   r_c1;
    logic signed [CURVE_W-1:0]   r_c2;
    logic [OUT_W-1:0]            r_out;

    // Arithmetic shifts floor toward minus infinity
    assign n_p1  = i_sample * $signed({1'b0, i_strength});
    assign n_p2  = r_c1 * $signed({1'b0, i_speed, 1'b0});
    assign n_sum = $signed({3'b000, i_speed, 1'b0}) + (OUT_W+2)'(r_c2);

    // Advance valid bits alongside the three data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_advance) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_c1  <= CURVE_W'(n_p1 >>> 15);
            r_c2  <= CURVE_W'(n_p2 >>> 15);
            r_out <= n_sum[OUT_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_speed = r_out;

    // The disturbance never drives the speed below zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && i_advance) |=> !n_sum[OUT_W+1])
        else $error("speed underflow");
endmodule

@@ design/misfire_speed_modulator_core.sv @@
// Misfire speed modulator: one tooth in per cycle unless stalled, and a
// result 2*speed plus a scaled misfire curve. The index, lookup, two multiplier
// stages and the final sum each hold one register level; the whole pipe moves when
// the output is free or taken. Configuration must be written while the pipe is empty.
// Top level; depends on msm_pkg, msm_index, msm_curve and msm_scale.
module misfire_speed_modulator_core #(
    parameter int TEETH_PER_CYCLE = msm_pkg::TEETH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [msm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [msm_pkg::TOOTH_W-1:0]    i_gear_tooth,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [msm_pkg::OUT_W-1:0]      o_modulated_speed
);
    import msm_pkg::*;

    logic [SPEED_W-1:0]        r_speed_hz;
    logic [STRENGTH_W-1:0]     r_strength;
    logic [PATTERN_W-1:0]      r_pattern;
    logic                      w_advance;
    logic                      w_v1;
    logic                      w_v2;
    logic [TOOTH_W-1:0]        w_index;
    t_curve                    w_curve;
    logic signed [CURVE_W-1:0] w_sample;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_hz <= '0;
            r_strength <= '0;
            r_pattern  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPEED:    r_speed_hz <= i_cfg_data[SPEED_W-1:0];
                CFG_STRENGTH: r_strength <= i_cfg_data[STRENGTH_W-1:0];
                CFG_PATTERN:  r_pattern  <= i_cfg_data[PATTERN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Advance the whole pipe unless a result waits stalled
    assign w_advance = !(o_valid && i_stall);
    assign o_stall   = !w_advance;

    msm_index #(.TEETH_PER_CYCLE(TEETH_PER_CYCLE)) u_index (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(w_advance),
        .i_valid(i_valid), .i_tooth(i_gear_tooth), .i_pattern(r_pattern),
        .o_valid(w_v1), .o_index(w_index), .o_curve(w_curve)
    );

    msm_curve u_curve (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(w_advance),
        .i_valid(w_v1), .i_index(w_index), .i_curve(w_curve),
        .o_valid(w_v2), .o_sample(w_sample)
    );

    msm_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(w_advance),
        .i_valid(w_v2), .i_sample(w_sample), .i_strength(r_strength),
        .i_speed(r_speed_hz), .o_valid(o_valid), .o_speed(o_modulated_speed)
    );

    // A stalled result holds its value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_modulated_speed)))
        else $error("stalled result changed");

    // Input is stalled only while a result is stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("spurious input stall");

    // Pattern off yields the doubled speed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_pattern == '0 && $past(r_pattern) == '0 &&
         $past(r_pattern, 2) == '0 && $past(r_pattern, 3) == '0 &&
         $stable(r_speed_hz) && $past(w_advance) && $past(w_advance, 2) &&
         $past(w_advance, 3) && $past(w_advance, 4) && $past(r_pattern, 4) == '0)
        |-> (o_modulated_speed == {1'b0, r_speed_hz, 1'b0}))
        else $error("disabled disturbance changed speed");
endmodule
